@@ rtl/pvh_pkg.sv @@
// Shared types, register map and carry-less multiply for the POLYVAL hash core.
// Used by polyval_universal_hash_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pvh_pkg;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned NBYTES  = 16;
  localparam int unsigned PADDR_W = 5;

  localparam logic [1:0] REG_KEY_LOW    = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH   = 2'd1;
  localparam logic [1:0] REG_START_LOW  = 2'd2;
  localparam logic [1:0] REG_START_HIGH = 2'd3;

  // high word of the reduction polynomial, bit-reflected form
  localparam logic [63:0] POLY_HI_WORD = 64'hc200_0000_0000_0000;

  typedef struct packed {
    logic        last_block;
    logic [4:0]  valid_bytes;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] tag_high;
    logic [63:0] tag_low;
  } out_item_t;

  function automatic logic [127:0] clmul64(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (a[i]) begin
        r = r ^ ({64'd0, b} << i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/polyval_universal_hash_core.sv @@
// POLYVAL universal hash core: top level with APB register port and one shared
// 64x64 carry-less multiplier. Depends on pvh_pkg.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one 16-byte
//   message block per transaction with its valid byte count and last flag.
//   Output channel (out_valid_o / out_stall_i / out_data_o) carries the
//   128-bit tag, one transaction per message, after its last block.
//   Key and start value are written through the APB port while idle.
// Timing:
//   Each block is accepted from idle, then makes six passes through the
//   shared carry-less multiplier (four partial products, two folds); the
//   input stays stalled until the passes are done. A tag is registered at
//   the last fold of its last block, or from hold; in_stall_o drops with it.
// Reset:
//   Key, start, accumulator, state and output valid registers clear; the
//   next block starts a message. Datapath and tag data registers do not.
// Back pressure:
//   The tag waits in the output register; the next block is accepted and
//   processed meanwhile. A further tag that finds the register occupied waits
//   in the accumulator and the input stays stalled until it moves out.
`timescale 1ns / 1ps
`default_nettype none

module polyval_universal_hash_core import pvh_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]    pwdata,
  output logic      [DATA_W-1:0]    prdata,
  output logic                      pready,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_item_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_item_t                 out_data_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  localparam logic [2:0] STEP_LL = 3'd0;
  localparam logic [2:0] STEP_LH = 3'd1;
  localparam logic [2:0] STEP_HL = 3'd2;
  localparam logic [2:0] STEP_HH = 3'd3;
  localparam logic [2:0] STEP_FL = 3'd4;
  localparam logic [2:0] STEP_FM = 3'd5;

  logic [63:0] key_low_q, key_high_q, start_low_q, start_high_q;
  logic [63:0] acc_low_q, acc_high_q;
  logic        in_msg_q;
  logic [1:0]  state_q;
  logic [2:0]  step_q;
  logic        last_q;
  logic [63:0] x0_q, x1_q;
  logic [63:0] l0_q, l1_q, m0_q, m1_q, h0_q, h1_q;
  logic        out_valid_q;
  out_item_t   out_data_q;

  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  logic        in_acc;
  logic        out_free;
  logic        tag_load;
  logic [63:0] mask_lo, mask_hi;
  logic [63:0] base_lo, base_hi;
  logic [63:0] op_a, op_b;
  logic [127:0] prod;
  logic [63:0] y0, y1;

  assign pready   = 1'b1;
  assign cfg_idx  = paddr[PADDR_W-1:3];
  assign cfg_wr   = psel & penable & pwrite;

  always_comb begin
    case (cfg_idx)
      REG_KEY_LOW:    prdata = key_low_q;
      REG_KEY_HIGH:   prdata = key_high_q;
      REG_START_LOW:  prdata = start_low_q;
      REG_START_HIGH: prdata = start_high_q;
      default:        prdata = '0;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign tag_load    = out_free & (((state_q == ST_BUSY) & (step_q == STEP_FM) & last_q) |
                                   (state_q == ST_HOLD));

  // byte masks; counts above sixteen keep every byte
  always_comb begin
    for (int k = 0; k < NBYTES / 2; k++) begin
      mask_lo[8*k +: 8] = {8{in_data_i.valid_bytes > 5'(k)}};
      mask_hi[8*k +: 8] = {8{in_data_i.valid_bytes > 5'(k + NBYTES / 2)}};
    end
  end

  assign base_lo = in_msg_q ? acc_low_q  : start_low_q;
  assign base_hi = in_msg_q ? acc_high_q : start_high_q;

  always_comb begin
    case (step_q)
      STEP_LL: begin op_a = x0_q; op_b = key_low_q;    end
      STEP_LH: begin op_a = x0_q; op_b = key_high_q;   end
      STEP_HL: begin op_a = x1_q; op_b = key_low_q;    end
      STEP_HH: begin op_a = x1_q; op_b = key_high_q;   end
      STEP_FL: begin op_a = l0_q; op_b = POLY_HI_WORD; end
      STEP_FM: begin op_a = m0_q; op_b = POLY_HI_WORD; end
      default: begin op_a = '0;   op_b = '0;           end
    endcase
  end

  assign prod = clmul64(op_a, op_b);

  // final fold result
  assign y0 = h0_q ^ m1_q ^ prod[63:0];
  assign y1 = h1_q ^ m0_q ^ prod[127:64];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q    <= '0;
      key_high_q   <= '0;
      start_low_q  <= '0;
      start_high_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_KEY_LOW:    key_low_q    <= pwdata;
        REG_KEY_HIGH:   key_high_q   <= pwdata;
        REG_START_LOW:  start_low_q  <= pwdata;
        REG_START_HIGH: start_high_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_LL;
      in_msg_q    <= 1'b0;
      acc_low_q   <= '0;
      acc_high_q  <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      out_valid_q <= tag_load | (out_valid_q & out_stall_i);
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_BUSY;
            step_q  <= STEP_LL;
            last_q  <= in_data_i.last_block;
          end
        end
        ST_BUSY: begin
          if (step_q == STEP_FM) begin
            acc_low_q  <= y0;
            acc_high_q <= y1;
            in_msg_q   <= ~last_q;
            if (!last_q || out_free) begin
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_HOLD;
            end
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x0_q <= base_lo ^ (in_data_i.block_low  & mask_lo);
      x1_q <= base_hi ^ (in_data_i.block_high & mask_hi);
    end
    if (state_q == ST_BUSY) begin
      case (step_q)
        STEP_LL: begin
          l0_q <= prod[63:0];
          l1_q <= prod[127:64];
        end
        STEP_LH: begin
          m0_q <= prod[63:0];
          m1_q <= prod[127:64];
        end
        STEP_HL: begin
          m0_q <= m0_q ^ prod[63:0];
          m1_q <= m1_q ^ prod[127:64];
        end
        STEP_HH: begin
          h0_q <= prod[63:0];
          h1_q <= prod[127:64];
        end
        STEP_FL: begin
          m0_q <= m0_q ^ l1_q ^ prod[63:0];
          m1_q <= m1_q ^ l0_q ^ prod[127:64];
        end
        default: ;
      endcase
    end
    if (state_q == ST_BUSY && step_q == STEP_FM && last_q && out_free) begin
      out_data_q.tag_low  <= y0;
      out_data_q.tag_high <= y1;
    end else if (state_q == ST_HOLD && out_free) begin
      out_data_q.tag_low  <= acc_low_q;
      out_data_q.tag_high <= acc_high_q;
    end
  end

endmodule

`default_nettype wire

@@ tb/polyval_universal_hash_core_tb.sv @@
// Self-checking testbench for polyval_universal_hash_core: random and directed blocks,
// APB key/start writes, a tag scoreboard with its own POLYVAL predictor.
// Depends on pvh_pkg and the polyval_universal_hash_core RTL.
`timescale 1ns / 1ps

module polyval_universal_hash_core_tb;
  import pvh_pkg::*;

  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG  = 2000;
  localparam int PHASES    = 7;
  localparam int PHASE_LEN = 100;

  class polyval_scoreboard;
    logic [127:0] hash_key;
    logic [127:0] init_val;
    logic [127:0] acc;
    bit           in_msg;
    out_item_t    expected_tags[$];
    int           errors;
    int           blocks_seen;
    int           tags_seen;

    function new();
      hash_key = '0;
      init_val = '0;
      acc      = '0;
      in_msg   = 1'b0;
      errors   = 0;
      blocks_seen = 0;
      tags_seen   = 0;
    endfunction

    function logic [127:0] gf_clmul(logic [63:0] a, logic [63:0] b);
      logic [127:0] r;
      r = '0;
      for (int i = 0; i < 64; i++) begin
        if (a[i]) r = r ^ ({64'd0, b} << i);
      end
      return r;
    endfunction

    // a * b * x^-128 mod x^128 + x^127 + x^126 + x^121 + 1
    function logic [127:0] poly_dot(logic [127:0] a, logic [127:0] b);
      logic [127:0] lo, mid, hi, t;
      lo  = gf_clmul(a[63:0], b[63:0]);
      mid = gf_clmul(a[63:0], b[127:64]) ^ gf_clmul(a[127:64], b[63:0]);
      hi  = gf_clmul(a[127:64], b[127:64]);
      t   = gf_clmul(lo[63:0], POLY_HI_WORD);
      mid[63:0]   = mid[63:0] ^ lo[127:64] ^ t[63:0];
      mid[127:64] = mid[127:64] ^ lo[63:0] ^ t[127:64];
      t   = gf_clmul(mid[63:0], POLY_HI_WORD);
      hi[63:0]    = hi[63:0] ^ mid[127:64] ^ t[63:0];
      hi[127:64]  = hi[127:64] ^ mid[63:0] ^ t[127:64];
      return hi;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        REG_KEY_LOW:    hash_key[63:0]   = val;
        REG_KEY_HIGH:   hash_key[127:64] = val;
        REG_START_LOW:  init_val[63:0]   = val;
        REG_START_HIGH: init_val[127:64] = val;
        default: ;
      endcase
    endfunction

    function void note_block(in_item_t it);
      logic [127:0] msg;
      int           nb;
      out_item_t    tag;
      nb  = it.valid_bytes;
      if (nb > 16) nb = 16;
      msg = {it.block_high, it.block_low};
      for (int b = 0; b < 16; b++) begin
        if (b >= nb) msg[8*b +: 8] = 8'h00;
      end
      if (!in_msg) acc = init_val;
      acc = poly_dot(acc ^ msg, hash_key);
      blocks_seen++;
      if (it.last_block) begin
        in_msg = 1'b0;
        tag.tag_low  = acc[63:0];
        tag.tag_high = acc[127:64];
        expected_tags.push_back(tag);
      end else begin
        in_msg = 1'b1;
      end
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH %s", $time, what);
      errors++;
    endtask

    task check_tag(out_item_t got);
      out_item_t want;
      if (expected_tags.size() == 0) begin
        report($sformatf("tag %h_%h with no message pending", got.tag_high, got.tag_low));
      end else begin
        want = expected_tags.pop_front();
        tags_seen++;
        if (got.tag_low !== want.tag_low)
          report($sformatf("tag_low got %h want %h", got.tag_low, want.tag_low));
        if (got.tag_high !== want.tag_high)
          report($sformatf("tag_high got %h want %h", got.tag_high, want.tag_high));
      end
    endtask

    task close_out();
      while (expected_tags.size() != 0) begin
        void'(expected_tags.pop_front());
        report("tag never delivered");
      end
    endtask

    function int pending();
      return expected_tags.size();
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [PADDR_W-1:0]  paddr       = '0;
  logic [DATA_W-1:0]   pwdata      = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;

  polyval_scoreboard   sb = new();
  int                  burst_left = 0;
  int                  msg_left   = 0;
  int                  hold_req   = 0;
  int                  hold_done  = 0;
  int                  settings_used = 0;
  int                  idle_cycles   = 0;

  always #5 clk_i = ~clk_i;

  polyval_universal_hash_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // transaction monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_tag(out_data_o);
      if (in_valid_i && !in_stall_o) sb.note_block(in_data_i);
      if (psel && penable && pwrite && pready) sb.write_reg(paddr[4:3], pwdata);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o) ||
          (psel && penable && pready)) begin
        idle_cycles = 0;
      end else if (idle_cycles >= WATCHDOG) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles++;
      end
    end
  end

  // receiver stall pattern
  initial begin
    int mode;
    int len;
    @(posedge clk_i);
    forever begin
      if (hold_req != hold_done) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_done++;
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(5, 60);
        repeat (len) begin
          case (mode)
            0: out_stall_i <= 1'b0;
            1: out_stall_i <= 1'($urandom_range(0, 1));
            2: out_stall_i <= ($urandom_range(0, 3) != 0);
            default: out_stall_i <= (len > 30);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  function automatic in_item_t make_item(logic [63:0] lo, logic [63:0] hi,
                                         logic [4:0] nb, logic last);
    in_item_t it;
    it.block_low   = lo;
    it.block_high  = hi;
    it.valid_bytes = nb;
    it.last_block  = last;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return '1;
    if (sel == 1) return '0;
    return {$urandom, $urandom};
  endfunction

  task automatic send_block(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // leaves the core idle with every tag collected
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_key(logic [127:0] key);
    write_reg(REG_KEY_LOW, key[63:0]);
    write_reg(REG_KEY_HIGH, key[127:64]);
  endtask

  task automatic set_start(logic [127:0] init);
    write_reg(REG_START_LOW, init[63:0]);
    write_reg(REG_START_HIGH, init[127:64]);
  endtask

  task automatic set_config(logic [127:0] key, logic [127:0] init);
    set_key(key);
    set_start(init);
    settings_used++;
  endtask

  task automatic send_random_block();
    logic [4:0] nb;
    int         sel;
    logic       last;
    if (msg_left == 0) msg_left = $urandom_range(1, 6);
    last = (msg_left == 1);
    msg_left--;
    sel = $urandom_range(0, 19);
    if (sel == 0)      nb = 5'd0;
    else if (sel == 1) nb = 5'($urandom_range(17, 31));
    else if (last || sel < 5) nb = 5'($urandom_range(1, 16));
    else               nb = 5'd16;
    send_block(make_item(rand64(), rand64(), nb, last));
  endtask

  initial begin
    logic [127:0] key;
    logic [127:0] init;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: byte counts at and past the edges, short inner block
    set_config({$urandom, $urandom, $urandom, $urandom},
               {$urandom, $urandom, $urandom, $urandom});
    send_block(make_item('1, '1, 5'd16, 1'b1));
    send_block(make_item('1, '1, 5'd1, 1'b1));
    send_block(make_item('1, '1, 5'd0, 1'b1));
    send_block(make_item('1, '1, 5'd31, 1'b1));
    send_block(make_item('1, '1, 5'd17, 1'b1));
    send_block(make_item(rand64(), rand64(), 5'd8, 1'b1));
    send_block(make_item(rand64(), rand64(), 5'd9, 1'b1));
    send_block(make_item(rand64(), rand64(), 5'd15, 1'b1));
    send_block(make_item('0, '0, 5'd16, 1'b1));
    send_block(make_item(rand64(), rand64(), 5'd16, 1'b0));
    send_block(make_item(rand64(), rand64(), 5'd5, 1'b0));
    send_block(make_item(rand64(), rand64(), 5'd16, 1'b1));

    // key change inside a message
    send_block(make_item(rand64(), rand64(), 5'd16, 1'b0));
    drain();
    set_key({$urandom, $urandom, $urandom, $urandom});
    send_block(make_item(rand64(), rand64(), 5'd12, 1'b1));

    // start value change inside a message only applies to the next one
    send_block(make_item(rand64(), rand64(), 5'd16, 1'b0));
    drain();
    set_start({$urandom, $urandom, $urandom, $urandom});
    send_block(make_item(rand64(), rand64(), 5'd16, 1'b0));
    send_block(make_item(rand64(), rand64(), 5'd3, 1'b1));
    send_block(make_item(rand64(), rand64(), 5'd16, 1'b1));
    drain();

    set_config('1, '1);
    send_block(make_item('1, '1, 5'd16, 1'b1));
    send_block(make_item(rand64(), rand64(), 5'd16, 1'b1));
    drain();
    set_config('0, {$urandom, $urandom, $urandom, $urandom});
    send_block(make_item(rand64(), rand64(), 5'd16, 1'b1));
    drain();
    set_config(128'd1, '0);
    send_block(make_item(rand64(), rand64(), 5'd16, 1'b0));
    send_block(make_item(rand64(), rand64(), 5'd7, 1'b1));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        1:       key = '1;
        2:       key = 128'd1;
        default: key = {$urandom, $urandom, $urandom, $urandom};
      endcase
      case (p % 3)
        1:       init = '0;
        2:       init = '1;
        default: init = {$urandom, $urandom, $urandom, $urandom};
      endcase
      set_config(key, init);
      if (p == 1) hold_req++;
      for (int i = 0; i < PHASE_LEN; i++) begin
        send_random_block();
        if ($urandom_range(0, 32) == 0) drain();
      end
      drain();
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    sb.close_out();
    $display("Run covered %0d blocks, %0d tags, %0d key/start settings; %0d mismatches",
             sb.blocks_seen, sb.tags_seen, settings_used, sb.errors);
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
